FILE: sv/assert_macros.svh
// Assertion macros shared by the frame builder modules.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/cfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame builder package
// Shared constants, job codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package cfb_pkg;

   // Fixed frame bytes.
   localparam logic [7:0] SOF_BYTE  = 8'h55;
   localparam logic [7:0] REPLY_BIT = 8'h80;
   localparam logic [7:0] EOF_BYTE  = 8'haa;

   // Input opcodes.
   localparam logic OP_START   = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   // Default depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Byte positions within a frame as the back end walks them.
   localparam logic [2:0] STEP_SOF = 3'd0;
   localparam logic [2:0] STEP_CMD = 3'd1;
   localparam logic [2:0] STEP_MID = 3'd2;
   localparam logic [2:0] STEP_CHK = 3'd3;
   localparam logic [2:0] STEP_EOF = 3'd4;

   // Kind of work the back end carries out for one accepted beat.
   typedef enum logic [1:0] {
      JOB_START = 2'b00,
      JOB_DATA  = 2'b01,
      JOB_STRAY = 2'b10
   } job_kind_type;

   // One queued job. The middle byte is the length for a start and the
   // payload byte for data. When tail is set the checksum and trailer follow.
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   cmd_byte;
      logic [7:0]   mid_byte;
      logic [7:0]   chk_byte;
      logic         tail;
   } job_type;

endpackage

FILE: sv/cfb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries one command or payload beat.
// ----------------------------------------------------------------------------
interface cfb_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] command_code;
   logic       is_reply;
   logic [7:0] payload_length;
   logic [7:0] data_byte;

   modport source (
      output valid, opcode, command_code, is_reply, payload_length, data_byte,
      input  ready
   );

   modport sink (
      input  valid, opcode, command_code, is_reply, payload_length, data_byte,
      output ready
   );
endinterface

FILE: sv/cfb_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel that carries one byte of the framed stream per beat.
// ----------------------------------------------------------------------------
interface cfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_frame;
   logic       last_of_run;
   logic       stray_byte;

   modport source (
      output valid, out_byte, end_of_frame, last_of_run, stray_byte,
      input  ready
   );

   modport sink (
      input  valid, out_byte, end_of_frame, last_of_run, stray_byte,
      output ready
   );
endinterface

FILE: sv/cfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame builder front end
// Accepts request beats, tracks the open frame and its checksum, and turns
// each beat into one job for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfb_front (
   input  logic             clock,
   input  logic             reset,
   cfb_req_if.sink          req_chan,
   output logic             push_valid,
   input  logic             push_ready,
   output cfb_pkg::job_type push_job
);
   import cfb_pkg::*;

   logic       frame_open_ff, frame_open_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] bytes_left_ff, bytes_left_in;

   logic       accept;
   logic [7:0] cmd_byte;
   logic [7:0] start_sum;
   logic [7:0] data_sum;
   logic [7:0] data_left;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign accept         = req_chan.valid && push_ready;

   // Header sums; the trailer byte is counted up front.
   assign cmd_byte  = req_chan.is_reply ? (req_chan.command_code | REPLY_BIT)
                                        : req_chan.command_code;
   assign start_sum = 8'(SOF_BYTE + cmd_byte + req_chan.payload_length + EOF_BYTE);
   assign data_sum  = 8'(running_sum_ff + req_chan.data_byte);
   assign data_left = 8'(bytes_left_ff - 8'd1);

   // Build the job and the next frame state for the beat on the channel.
   always_comb begin
      frame_open_in  = frame_open_ff;
      running_sum_in = running_sum_ff;
      bytes_left_in  = bytes_left_ff;
      push_job.kind     = JOB_STRAY;
      push_job.cmd_byte = cmd_byte;
      push_job.mid_byte = req_chan.data_byte;
      push_job.chk_byte = 8'(8'd0 - data_sum);
      push_job.tail     = 1'b0;
      if (req_chan.opcode == OP_START) begin
         push_job.kind     = JOB_START;
         push_job.mid_byte = req_chan.payload_length;
         push_job.chk_byte = 8'(8'd0 - start_sum);
         if (req_chan.payload_length == 8'd0) begin
            // Empty frame closes at once.
            push_job.tail  = 1'b1;
            frame_open_in  = 1'b0;
            running_sum_in = 8'd0;
            bytes_left_in  = 8'd0;
         end else begin
            frame_open_in  = 1'b1;
            running_sum_in = start_sum;
            bytes_left_in  = req_chan.payload_length;
         end
      end else if (frame_open_ff) begin
         push_job.kind = JOB_DATA;
         if (data_left == 8'd0) begin
            push_job.tail  = 1'b1;
            frame_open_in  = 1'b0;
            running_sum_in = 8'd0;
            bytes_left_in  = 8'd0;
         end else begin
            running_sum_in = data_sum;
            bytes_left_in  = data_left;
         end
      end
   end

   // Frame state advances only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff  <= 1'b0;
         running_sum_ff <= 8'd0;
         bytes_left_ff  <= 8'd0;
      end else if (accept) begin
         frame_open_ff  <= frame_open_in;
         running_sum_ff <= running_sum_in;
         bytes_left_ff  <= bytes_left_in;
      end
   end

   `ASSERT_IMPLIES(a_open_has_bytes, clock, reset, frame_open_ff, bytes_left_ff != 8'd0,
      "open frame with no payload bytes due")
   `ASSERT_IMPLIES(a_closed_is_clear, clock, reset, !frame_open_ff,
      running_sum_ff == 8'd0 && bytes_left_ff == 8'd0, "closed frame left state behind")

endmodule

FILE: sv/cfb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame builder job queue
// Small first-word-fall-through queue that decouples front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfb_queue #(
   parameter int Depth = cfb_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cfb_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop,
   output cfb_pkg::job_type pop_job
);
   import cfb_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push_fire;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_job    = mem_ff[rd_ptr_ff];

   // Pointers wrap at the last entry; occupancy follows push and pop.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push_fire && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push_fire) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, count_ff != '0,
      "job popped from an empty queue")
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CntW'(Depth),
      "queue occupancy above its depth")

endmodule

FILE: sv/cfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame builder back end
// Walks the head job one byte per cycle, unless the response channel stalls,
// into a registered response beat, popping the job with its last byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop,
   input  cfb_pkg::job_type pop_job,
   cfb_rsp_if.source        rsp_chan
);
   import cfb_pkg::*;

   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       end_of_frame_ff;
   logic       last_of_run_ff;
   logic       stray_byte_ff;

   logic       load;
   logic [2:0] pos;
   logic [7:0] next_byte;
   logic       next_eof;
   logic       next_last;
   logic       next_stray;

   // Data jobs enter the frame walk at the middle byte.
   assign pos = (pop_job.kind == JOB_DATA) ? 3'(step_ff + STEP_MID) : step_ff;

   // Select the byte for the current position of the head job.
   always_comb begin
      next_eof   = 1'b0;
      next_stray = 1'b0;
      next_last  = 1'b0;
      unique case (pos)
         STEP_SOF: next_byte = SOF_BYTE;
         STEP_CMD: next_byte = pop_job.cmd_byte;
         STEP_MID: begin
            next_byte = pop_job.mid_byte;
            next_last = !pop_job.tail;
         end
         STEP_CHK: next_byte = pop_job.chk_byte;
         STEP_EOF: begin
            next_byte = EOF_BYTE;
            next_eof  = 1'b1;
            next_last = 1'b1;
         end
         default:  next_byte = 8'd0;
      endcase
      if (pop_job.kind == JOB_STRAY) begin
         next_byte  = 8'd0;
         next_eof   = 1'b0;
         next_stray = 1'b1;
         next_last  = 1'b1;
      end
   end

   // The output register takes a new beat when empty or being drained.
   assign load = pop_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign pop  = load && next_last;

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         step_in      = next_last ? 3'd0 : 3'(step_ff + 3'd1);
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff     <= next_byte;
         end_of_frame_ff <= next_eof;
         last_of_run_ff  <= next_last;
         stray_byte_ff   <= next_stray;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_byte     = out_byte_ff;
   assign rsp_chan.end_of_frame = end_of_frame_ff;
   assign rsp_chan.last_of_run  = last_of_run_ff;
   assign rsp_chan.stray_byte   = stray_byte_ff;

   `ASSERT_IMPLIES(a_eof_ends_run, clock, reset, rsp_valid_ff && end_of_frame_ff,
      last_of_run_ff && !stray_byte_ff, "trailer beat not marked last")
   `ASSERT_NEXT(a_pop_resets_step, clock, reset, pop, step_ff == 3'd0,
      "step counter not cleared after job")

endmodule

FILE: sv/command_frame_builder_top.sv
`timescale 1ns / 1ps
// Command frame builder. Each request beat is either a start (command, reply
// flag, length) or one payload byte; the response channel carries the framed
// stream 0x55, command, length, payload, checksum, 0xaa one byte per beat, with
// last_of_run marking the final byte caused by each request. A request is
// accepted in any cycle the job queue has room. The job is written into the
// queue, and the back end then registers its first byte into the response
// register before it is presented on the response channel. The back end emits
// one byte per cycle while the response channel is ready, so a payload beat
// yields one byte, a start beat three bytes, and the closing beat of a frame
// (the last payload byte, or an empty start) three or five bytes; the queue
// absorbs these bursts while requests keep flowing.
// ----------------------------------------------------------------------------
// Command frame builder top level
// Connects the front end, job queue and back end.
// ----------------------------------------------------------------------------
module command_frame_builder_top #(
   parameter int QueueDepth = cfb_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   cfb_req_if.sink    req_chan,
   cfb_rsp_if.source  rsp_chan
);
   import cfb_pkg::*;

   logic    push_valid;
   logic    push_ready;
   job_type push_job;
   logic    pop_valid;
   logic    pop;
   job_type pop_job;

   cfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   cfb_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_job    (pop_job)
   );

   cfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_job   (pop_job),
      .rsp_chan  (rsp_chan)
   );

endmodule

FILE: test/tb_command_frame_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame builder testbench
// Drives start and payload beats into the frame builder with random gaps on
// the request side and random stalls on the response side. A scoreboard
// predicts every framed byte, including the header, the checksum, the
// trailer and stray-byte flags, and compares each response beat in order.
// ----------------------------------------------------------------------------
module tb_command_frame_builder_top;
   import cfb_pkg::*;

   // One request beat as the testbench sees it.
   typedef struct packed {
      logic       opcode;
      logic [7:0] command_code;
      logic       is_reply;
      logic [7:0] payload_length;
      logic [7:0] data_byte;
   } cmd_req_type;

   // One byte of the framed stream with its flags.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_frame;
      logic       last_of_run;
      logic       stray_byte;
   } framed_beat_type;

   // Predicts the framed stream and checks response beats against it.
   class frame_scoreboard_type;
      bit              frame_active;
      logic [7:0]      frame_sum;
      logic [7:0]      payload_due;
      framed_beat_type pending[$];
      int              error_count;
      int              beats_checked;
      int              frames_closed;
      int              strays_flagged;

      function void push_beat(logic [7:0] b, logic eof, logic last, logic stray);
         framed_beat_type fb;
         fb.out_byte     = b;
         fb.end_of_frame = eof;
         fb.last_of_run  = last;
         fb.stray_byte   = stray;
         pending.push_back(fb);
      endfunction

      // Checksum and trailer close the frame and clear the state.
      function void push_tail();
         push_beat(8'h00 - frame_sum, 1'b0, 1'b0, 1'b0);
         push_beat(EOF_BYTE, 1'b1, 1'b1, 1'b0);
         frame_active = 1'b0;
         payload_due  = 8'h00;
         frame_sum    = 8'h00;
         frames_closed++;
      endfunction

      function void note_request(cmd_req_type r);
         logic [7:0] cbyte;
         if (r.opcode == OP_START) begin
            // A start always opens a new frame, abandoning any open one.
            cbyte        = r.is_reply ? (r.command_code | REPLY_BIT) : r.command_code;
            frame_sum    = SOF_BYTE + cbyte + r.payload_length + EOF_BYTE;
            payload_due  = r.payload_length;
            frame_active = 1'b1;
            push_beat(SOF_BYTE, 1'b0, 1'b0, 1'b0);
            push_beat(cbyte, 1'b0, 1'b0, 1'b0);
            if (r.payload_length == 8'h00) begin
               push_beat(8'h00, 1'b0, 1'b0, 1'b0);
               push_tail();
            end else begin
               push_beat(r.payload_length, 1'b0, 1'b1, 1'b0);
            end
         end else if (!frame_active) begin
            // Payload with no open frame is dropped and flagged.
            push_beat(8'h00, 1'b0, 1'b1, 1'b1);
            strays_flagged++;
         end else begin
            frame_sum   = frame_sum + r.data_byte;
            payload_due = payload_due - 8'd1;
            if (payload_due == 8'h00) begin
               push_beat(r.data_byte, 1'b0, 1'b0, 1'b0);
               push_tail();
            end else begin
               push_beat(r.data_byte, 1'b0, 1'b1, 1'b0);
            end
         end
      endfunction

      function void check_response(framed_beat_type got);
         framed_beat_type want;
         if (pending.size() == 0) begin
            $error("unexpected response beat: out_byte %h", got.out_byte);
            error_count++;
            return;
         end
         want = pending.pop_front();
         beats_checked++;
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            error_count++;
         end
         if (got.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %b, got %b", want.end_of_frame,
                   got.end_of_frame);
            error_count++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
            error_count++;
         end
         if (got.stray_byte !== want.stray_byte) begin
            $error("stray_byte: expected %b, got %b", want.stray_byte, got.stray_byte);
            error_count++;
         end
      endfunction
   endclass

   localparam int RANDOM_ITEMS = 500;

   logic clock;
   logic reset;
   bit   steady;
   int   items_sent;

   frame_scoreboard_type sb;

   cfb_req_if req_chan ();
   cfb_rsp_if rsp_chan ();

   command_frame_builder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Free-running clock.
   always #10 clock = ~clock;

   // Mostly short gaps, a few long ones, none during steady stretches.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Unused fields of each opcode carry random values.
   function automatic cmd_req_type make_start(logic [7:0] cmd, logic reply, logic [7:0] len);
      cmd_req_type r;
      r.opcode         = OP_START;
      r.command_code   = cmd;
      r.is_reply       = reply;
      r.payload_length = len;
      r.data_byte      = 8'($urandom);
      return r;
   endfunction

   function automatic cmd_req_type make_payload(logic [7:0] data);
      cmd_req_type r;
      r.opcode         = OP_PAYLOAD;
      r.command_code   = 8'($urandom);
      r.is_reply       = 1'($urandom);
      r.payload_length = 8'($urandom);
      r.data_byte      = data;
      return r;
   endfunction

   // Drive one request beat after a random gap and wait for its handshake.
   task automatic send_request(input cmd_req_type r);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid          <= 1'b0;
         req_chan.opcode         <= 1'($urandom);
         req_chan.command_code   <= 8'($urandom);
         req_chan.is_reply       <= 1'($urandom);
         req_chan.payload_length <= 8'($urandom);
         req_chan.data_byte      <= 8'($urandom);
      end
      @(negedge clock);
      req_chan.valid          <= 1'b1;
      req_chan.opcode         <= r.opcode;
      req_chan.command_code   <= r.command_code;
      req_chan.is_reply       <= r.is_reply;
      req_chan.payload_length <= r.payload_length;
      req_chan.data_byte      <= r.data_byte;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(r);
      items_sent++;
   endtask

   // A start followed by a given number of random payload bytes.
   task automatic send_frame(input logic [7:0] len, input int count);
      send_request(make_start(8'($urandom), 1'($urandom), len));
      repeat (count) send_request(make_payload(8'($urandom)));
   endtask

   function automatic logic [7:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 8'd0;
      if (r < 80) return 8'($urandom_range(1, 8));
      if (r < 97) return 8'($urandom_range(9, 40));
      return 8'($urandom_range(41, 255));
   endfunction

   // Response side: random stalls between bursts of readiness.
   initial begin
      int stall;
      int burst;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = pick_gap();
         repeat (stall) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
         repeat (burst) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Check every accepted response beat.
   always @(posedge clock) begin
      framed_beat_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.out_byte     = rsp_chan.out_byte;
         got.end_of_frame = rsp_chan.end_of_frame;
         got.last_of_run  = rsp_chan.last_of_run;
         got.stray_byte   = rsp_chan.stray_byte;
         sb.check_response(got);
      end
   end

   // Run limit.
   initial begin
      #20ms;
      $display("tb_command_frame_builder_top: errors");
      $finish;
   end

   // Main sequence.
   initial begin
      int random_start;
      int pick;
      int len;
      int partial;
      bit long_done;

      sb                      = new();
      clock                   = 1'b0;
      reset                   = 1'b1;
      steady                  = 1'b0;
      items_sent              = 0;
      long_done               = 1'b0;
      req_chan.valid          = 1'b0;
      req_chan.opcode         = OP_START;
      req_chan.command_code   = 8'h00;
      req_chan.is_reply       = 1'b0;
      req_chan.payload_length = 8'h00;
      req_chan.data_byte      = 8'h00;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: stray payload straight out of reset.
      send_request(make_payload(8'hff));
      // Zero-length frames at both command extremes.
      send_request(make_start(8'h00, 1'b0, 8'd0));
      send_request(make_start(8'hff, 1'b1, 8'd0));
      // One- and two-byte payloads, reply bit on and off.
      send_request(make_start(8'h7f, 1'b1, 8'd1));
      send_request(make_payload(8'hff));
      send_request(make_start(8'h80, 1'b0, 8'd2));
      send_request(make_payload(8'h00));
      send_request(make_payload(8'ha5));
      // Stray after a closed frame.
      send_request(make_payload(8'h3c));
      // A frame abandoned by a new start, then a clean one-byte frame.
      send_request(make_start(8'h41, 1'b0, 8'd3));
      send_request(make_payload(8'h11));
      send_request(make_start(8'h12, 1'b0, 8'd1));
      send_request(make_payload(8'h5a));
      // Maximum length header abandoned by a zero-length start.
      send_request(make_start(8'h01, 1'b1, 8'd255));
      send_request(make_payload(8'h80));
      send_request(make_start(8'hfe, 1'b0, 8'd0));
      // Back-to-back strays.
      send_request(make_payload(8'h01));
      send_request(make_payload(8'h7e));

      // Random part: mostly whole frames, some broken ones and strays.
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 9) < 2);
         pick   = $urandom_range(0, 99);
         if (!long_done && items_sent - random_start > 150) begin
            send_frame(8'd255, 255);
            long_done = 1'b1;
         end else if (pick < 75) begin
            len = int'(pick_length());
            send_frame(8'(len), len);
         end else if (pick < 88) begin
            len     = $urandom_range(2, 12);
            partial = $urandom_range(1, len - 1);
            send_frame(8'(len), partial);
         end else begin
            repeat ($urandom_range(1, 3)) send_request(make_payload(8'($urandom)));
         end
      end
      steady = 1'b0;

      @(negedge clock);
      req_chan.valid <= 1'b0;

      // Drain outstanding bytes, then allow a few idle cycles.
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Accepted %0d request beats; checked %0d framed bytes.", items_sent,
               sb.beats_checked);
      $display("Closed %0d frames and saw %0d stray payload beats.", sb.frames_closed,
               sb.strays_flagged);
      if (sb.error_count == 0 && sb.pending.size() == 0) begin
         $display("tb_command_frame_builder_top: clean");
      end else begin
         $display("tb_command_frame_builder_top: errors");
      end
      $finish;
   end

endmodule
